// File: src/encapsulated_fragment_deframer_unit_defines.svh
// assertion helpers used by the checker file efd_checker.sv
`ifndef ENCAPSULATED_FRAGMENT_DEFRAMER_UNIT_DEFINES_SVH
`define ENCAPSULATED_FRAGMENT_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define EFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define EFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/efd_pkg.sv
package efd_pkg;

    // tags and framing
    localparam logic [31:0] ITEM_TAG     = 32'hFFFE_E000;
    localparam logic [31:0] DELIM_TAG    = 32'hFFFE_E0DD;
    localparam logic [31:0] PREAMBLE_LEN = 32'd8;
    localparam int          HDR_BYTES    = 8;

    // result kinds
    localparam logic [1:0] KIND_FRAG = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // result queue sizing
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] frag_offset;
        logic [31:0] frag_length;
        logic [31:0] bad_tag;
        logic        run_end;
    } result_t;

    // up to two results produced by one byte, first one in r0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

// File: src/efd_parser.sv
module efd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    output logic           busy,
    output efd_pkg::push_t push
);
    import efd_pkg::*;

    typedef enum logic [1:0] {
        PH_PREAMBLE = 2'd0,
        PH_HEADER   = 2'd1,
        PH_PAYLOAD  = 2'd2
    } phase_t;

    localparam int          HDR_W    = (HDR_BYTES - 1) * 8;
    localparam logic [2:0]  HCNT_LAST = 3'(HDR_BYTES - 1);

    logic        s1_valid_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_last_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic [HDR_W-1:0] hdr_reg, hdr_next;
    logic [31:0] skip_reg, skip_next;
    logic        stopped_reg, stopped_next;

    logic [63:0] full_hdr;
    logic [31:0] tag;
    logic [31:0] len;
    logic [31:0] skip_dec;
    logic        hdr_v;
    logic        end_v;
    result_t     hdr_res;
    result_t     end_res;

    assign busy = s1_valid_reg;

    // byte processing and state update
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        hcnt_next    = hcnt_reg;
        hdr_next     = hdr_reg;
        skip_next    = skip_reg;
        stopped_next = stopped_reg;
        full_hdr     = {s1_data_reg, hdr_reg};
        tag          = {full_hdr[15:0], full_hdr[31:16]};
        len          = full_hdr[63:32];
        skip_dec     = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;
        hdr_v        = 1'b0;
        end_v        = 1'b0;
        hdr_res      = '0;
        end_res      = '0;
        end_res.kind    = KIND_END;
        end_res.run_end = 1'b1;

        if (s1_valid_reg)
        begin
            if (!stopped_reg)
            begin
                case (phase_reg)
                    PH_PREAMBLE, PH_PAYLOAD:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 32'd0)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        if (hcnt_reg == HCNT_LAST)
                        begin
                            hdr_next  = '0;
                            hcnt_next = 3'd0;
                            hdr_v     = 1'b1;
                            if (tag == ITEM_TAG)
                            begin
                                hdr_res.kind        = KIND_FRAG;
                                hdr_res.frag_offset = pos_reg + 32'd1;
                                hdr_res.frag_length = len;
                                skip_next           = len;
                                phase_next = (len == 32'd0) ? PH_HEADER : PH_PAYLOAD;
                            end
                            else if (tag == DELIM_TAG)
                            begin
                                hdr_res.kind = KIND_DONE;
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                hdr_res.kind    = KIND_BAD;
                                hdr_res.bad_tag = tag;
                                stopped_next    = 1'b1;
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < HDR_BYTES - 1; i++)
                            begin
                                if (hcnt_reg == 3'(i))
                                begin
                                    hdr_next[i*8 +: 8] = s1_data_reg;
                                end
                            end
                            hcnt_next = hcnt_reg + 3'd1;
                        end
                    end
                endcase
            end

            pos_next = pos_reg + 32'd1;

            // end of buffer: closing result unless stopped, then back to reset values
            if (s1_last_reg)
            begin
                end_v           = !stopped_next;
                hdr_res.run_end = !end_v;
                phase_next      = PH_PREAMBLE;
                pos_next        = 32'd0;
                hcnt_next       = 3'd0;
                hdr_next        = '0;
                skip_next       = PREAMBLE_LEN;
                stopped_next    = 1'b0;
            end
        end
    end

    // pack results so the first one always sits in r0
    always_comb
    begin
        push.v0 = hdr_v || end_v;
        push.v1 = hdr_v && end_v;
        push.r0 = hdr_v ? hdr_res : end_res;
        push.r1 = end_res;
    end

    // input register and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_PREAMBLE;
            pos_reg      <= 32'd0;
            hcnt_reg     <= 3'd0;
            hdr_reg      <= '0;
            skip_reg     <= PREAMBLE_LEN;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            hcnt_reg     <= hcnt_next;
            hdr_reg      <= hdr_next;
            skip_reg     <= skip_next;
            stopped_reg  <= stopped_next;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

endmodule

// File: src/efd_result_queue.sv
module efd_result_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  efd_pkg::push_t            push,
    input  logic                      pop,
    output logic                      not_empty,
    output logic [efd_pkg::QCNT_W-1:0] count,
    output efd_pkg::result_t          head
);
    import efd_pkg::*;

    result_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QCNT_W-1:0] npush;
    logic              do_pop;

    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;
    assign head      = mem[rd_reg];
    assign do_pop    = pop && not_empty;

    // pointer and occupancy update
    always_comb
    begin
        npush    = QCNT_W'(push.v0) + QCNT_W'(push.v1);
        wr_next  = wr_reg + QPTR_W'(npush);
        rd_next  = do_pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + npush - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage, up to two writes per cycle at consecutive slots
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_reg + QPTR_W'(1)] <= push.r1;
        end
    end

endmodule

// File: src/encapsulated_fragment_deframer_unit.sv
// path: an accepted byte is registered in the parser, then its results are queued
// throughput: one byte per cycle; results leave one per cycle unless result_stall
// is high, from an eight-entry queue, and a byte stalls unless the queue has room
// for two results of the byte in flight and two more of the byte offered
// reset: rst_n asynchronous active low, clears parser state and empties the queue
module encapsulated_fragment_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [31:0] frag_offset,
    output logic [31:0] frag_length,
    output logic [31:0] bad_tag,
    output logic        run_end
);
    import efd_pkg::*;

    logic              accept;
    logic              busy;
    push_t             push;
    logic [QCNT_W-1:0] count;
    logic [QCNT_W:0]   need;
    result_t           head;

    // reserve room for the byte in flight and the one being offered
    assign need       = {1'b0, count} + (busy ? (QCNT_W + 1)'(2) : '0);
    assign data_stall = (need > (QCNT_W + 1)'(QDEPTH - 2));
    assign accept     = data_valid && !data_stall;

    efd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .busy      (busy),
        .push      (push)
    );

    efd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (!result_stall),
        .not_empty (result_valid),
        .count     (count),
        .head      (head)
    );

    assign kind        = head.kind;
    assign frag_offset = head.frag_offset;
    assign frag_length = head.frag_length;
    assign bad_tag     = head.bad_tag;
    assign run_end     = head.run_end;

endmodule

// File: src/efd_checker.sv
`include "encapsulated_fragment_deframer_unit_defines.svh"

module efd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [1:0]  kind,
    input logic [31:0] frag_offset,
    input logic [31:0] frag_length,
    input logic [31:0] bad_tag,
    input logic        run_end
);
    import efd_pkg::*;

    // a stalled result stays offered
    `EFD_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid,
                     "result dropped while stalled")

    // only fragments carry offset and length
    `EFD_ASSERT_NOW(a_frag_fields, result_valid && kind != KIND_FRAG,
                    frag_offset == 32'd0 && frag_length == 32'd0,
                    "fragment fields set on non-fragment")

    // only an unexpected tag carries a tag value
    `EFD_ASSERT_NOW(a_bad_tag, result_valid && kind != KIND_BAD, bad_tag == 32'd0,
                    "tag set on non-error result")

    // a fragment is never the final result of its buffer
    `EFD_ASSERT_NOW(a_frag_not_last, result_valid && kind == KIND_FRAG, !run_end,
                    "fragment marked as final result")

endmodule

bind encapsulated_fragment_deframer_unit efd_checker u_efd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .frag_offset  (frag_offset),
    .frag_length  (frag_length),
    .bad_tag      (bad_tag),
    .run_end      (run_end)
);
